// File: rtl/core/iwt_pkg.sv
// Shared types and constants for the IRQ wait table.
package iwt_pkg;

    // Operation codes carried in the op field
    localparam logic [1:0] OP_WAIT    = 2'd0;
    localparam logic [1:0] OP_POST    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_BUSY       = 3'd2;
    localparam logic [2:0] ST_NOMEM      = 3'd3;
    localparam logic [2:0] ST_WOULDBLOCK = 3'd4;

    // Timeout value that never expires
    localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

    // One stored waiter (valid bit is kept outside the RAM)
    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  irq;
        logic        ready;
        logic [31:0] limit;
        logic [31:0] start;
        logic [7:0]  evirq;
        logic [31:0] stamp;
        logic [31:0] data;
        logic [31:0] context_word;
    } entry_t;

    // One accepted input transaction
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  task_id;
        logic [7:0]  irq;
        logic [31:0] wait_timeout;
        logic [31:0] now_tick;
        logic [31:0] cycle_stamp;
        logic [31:0] post_data;
        logic [31:0] post_context;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  event_irq;
        logic [31:0] event_stamp;
        logic [31:0] event_data;
        logic [31:0] event_context;
    } result_t;

endpackage

// File: rtl/core/iwt_in_if.sv
// Request channel interface of the IRQ wait table.
interface iwt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  task_id;
    logic [7:0]  irq;
    logic [31:0] wait_timeout;
    logic [31:0] now_tick;
    logic [31:0] cycle_stamp;
    logic [31:0] post_data;
    logic [31:0] post_context;

    modport source (
        output valid, op, task_id, irq, wait_timeout, now_tick, cycle_stamp,
               post_data, post_context,
        input  ready
    );

    modport sink (
        input  valid, op, task_id, irq, wait_timeout, now_tick, cycle_stamp,
               post_data, post_context,
        output ready
    );
endinterface

// File: rtl/core/iwt_out_if.sv
// Response channel interface of the IRQ wait table.
interface iwt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  event_irq;
    logic [31:0] event_stamp;
    logic [31:0] event_data;
    logic [31:0] event_context;

    modport source (
        output valid, status, event_irq, event_stamp, event_data, event_context,
        input  ready
    );

    modport sink (
        input  valid, status, event_irq, event_stamp, event_data, event_context,
        output ready
    );
endinterface

// File: rtl/core/iwt_entry_ram.sv
// Waiter entry RAM: one write port, one read port, registered read data.
module iwt_entry_ram #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  iwt_pkg::entry_t            wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output iwt_pkg::entry_t            rd_data
);

    iwt_pkg::entry_t mem [DEPTH];
    iwt_pkg::entry_t rdata_reg;

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

// File: rtl/core/iwt_out_reg.sv
// Output register that holds one result until the sink takes it.
module iwt_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  iwt_pkg::result_t  din,
    output logic              free,
    iwt_out_if.source         rsp
);

    logic             valid_reg;
    logic             valid_next;
    iwt_pkg::result_t data_reg;

    // Slot is free when empty or being emptied this cycle
    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.status        = data_reg.status;
    assign rsp.event_irq     = data_reg.event_irq;
    assign rsp.event_stamp   = data_reg.event_stamp;
    assign rsp.event_data    = data_reg.event_data;
    assign rsp.event_context = data_reg.event_context;

endmodule

// File: rtl/core/irq_wait_table.sv
// Top level of the IRQ wait table: scan sequencer around the entry RAM.
//
// Each request transaction (wait, post, timeout check, remove task) walks the
// whole table once: one RAM read per entry, each entry read-modified-written
// in the cycle after its read, then a drain state empties the read pipeline
// and a finish state builds the answer, holding until the output register is
// free; only then can the block take the next request. Exactly one response
// comes back for every request, in order. A finished response waits in an
// output register, so the next request can be accepted while it is pending.
// Entry valid bits live in flip-flops and are cleared by reset; the RAM
// contents need no clearing.
module irq_wait_table #(
    parameter int WAIT_ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    iwt_in_if.sink    req,
    iwt_out_if.source rsp
);

    localparam int IDX_W = $clog2(WAIT_ENTRIES);

    // Sequencer states
    localparam logic [1:0] SEQ_IDLE   = 2'd0;
    localparam logic [1:0] SEQ_SCAN   = 2'd1;
    localparam logic [1:0] SEQ_DRAIN  = 2'd2;
    localparam logic [1:0] SEQ_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]        proc_idx_reg, proc_idx_next;
    iwt_pkg::item_t          item_reg, item_next;
    logic                    match_reg, match_next;
    iwt_pkg::entry_t         hit_reg, hit_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [WAIT_ENTRIES-1:0] valid_reg, valid_next;

    logic             in_acc;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    iwt_pkg::entry_t  wr_data;
    iwt_pkg::entry_t  rd_data;
    logic             out_free;
    logic             out_load;
    iwt_pkg::result_t result;
    logic             ent_valid;
    logic [31:0]      elapsed;
    logic             last_rd;

    assign req.ready = (state_reg == SEQ_IDLE);
    assign in_acc    = req.valid && req.ready;
    assign rd_en     = (state_reg == SEQ_SCAN);
    assign last_rd   = (rd_idx_reg == IDX_W'(WAIT_ENTRIES - 1));
    assign ent_valid = valid_reg[proc_idx_reg];
    assign elapsed   = item_reg.now_tick - rd_data.start;
    assign out_load  = (state_reg == SEQ_FINISH) && out_free;

    iwt_entry_ram #(
        .DEPTH (WAIT_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    iwt_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .din   (result),
        .free  (out_free),
        .rsp   (rsp)
    );

    // Sequencer, per-entry update and result build
    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = rd_idx_reg;
        item_next       = item_reg;
        match_next      = match_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        wr_en           = 1'b0;
        wr_addr         = proc_idx_reg;
        wr_data         = rd_data;
        result          = '0;
        result.status   = iwt_pkg::ST_OK;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_acc)
                begin
                    item_next.op           = req.op;
                    item_next.task_id      = req.task_id;
                    item_next.irq          = req.irq;
                    item_next.wait_timeout = req.wait_timeout;
                    item_next.now_tick     = req.now_tick;
                    item_next.cycle_stamp  = req.cycle_stamp;
                    item_next.post_data    = req.post_data;
                    item_next.post_context = req.post_context;
                    rd_idx_next            = '0;
                    match_next             = 1'b0;
                    free_found_next        = 1'b0;
                    state_next             = SEQ_SCAN;
                end
            end
            SEQ_SCAN:
            begin
                proc_vld_next = 1'b1;
                rd_idx_next   = rd_idx_reg + 1'b1;
                if (last_rd)
                begin
                    rd_idx_next = '0;
                    state_next  = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN:
            begin
                state_next = SEQ_FINISH;
            end
            SEQ_FINISH:
            begin
                if (out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        // Entry read last cycle: read-modify-write
        if (proc_vld_reg)
        begin
            unique case (item_reg.op)
                iwt_pkg::OP_WAIT:
                begin
                    if (ent_valid && rd_data.task_id == item_reg.task_id
                        && rd_data.irq == item_reg.irq && item_reg.task_id != 8'd0)
                    begin
                        match_next = 1'b1;
                        hit_next   = rd_data;
                        if (rd_data.ready)
                        begin
                            valid_next[proc_idx_reg] = 1'b0;
                        end
                    end
                    else if (!ent_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx_reg;
                    end
                end
                iwt_pkg::OP_POST:
                begin
                    if (ent_valid && !rd_data.ready && rd_data.irq == item_reg.irq)
                    begin
                        wr_en                = 1'b1;
                        wr_data.evirq        = item_reg.irq;
                        wr_data.stamp        = item_reg.cycle_stamp;
                        wr_data.data         = item_reg.post_data;
                        wr_data.context_word = item_reg.post_context;
                        wr_data.ready        = 1'b1;
                    end
                end
                iwt_pkg::OP_TIMEOUT:
                begin
                    if (ent_valid && !rd_data.ready && rd_data.limit != iwt_pkg::FOREVER
                        && elapsed >= rd_data.limit)
                    begin
                        wr_en         = 1'b1;
                        wr_data.ready = 1'b1;
                    end
                end
                iwt_pkg::OP_REMOVE:
                begin
                    if (ent_valid && item_reg.task_id != 8'd0
                        && rd_data.task_id == item_reg.task_id)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Answer; a blocking wait also inserts its new entry here
        if (item_reg.op == iwt_pkg::OP_WAIT)
        begin
            priority if (item_reg.task_id == 8'd0)
            begin
                result.status = iwt_pkg::ST_INVALID;
            end
            else if (match_reg && hit_reg.ready)
            begin
                result.status        = iwt_pkg::ST_OK;
                result.event_irq     = hit_reg.evirq;
                result.event_stamp   = hit_reg.stamp;
                result.event_data    = hit_reg.data;
                result.event_context = hit_reg.context_word;
            end
            else if (match_reg)
            begin
                result.status = iwt_pkg::ST_BUSY;
            end
            else if (free_found_reg)
            begin
                result.status = iwt_pkg::ST_WOULDBLOCK;
                if (out_load)
                begin
                    wr_en                    = 1'b1;
                    wr_addr                  = free_idx_reg;
                    wr_data                  = '0;
                    wr_data.task_id          = item_reg.task_id;
                    wr_data.irq              = item_reg.irq;
                    wr_data.limit            = item_reg.wait_timeout;
                    wr_data.start            = item_reg.now_tick;
                    valid_next[free_idx_reg] = 1'b1;
                end
            end
            else
            begin
                result.status = iwt_pkg::ST_NOMEM;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            proc_vld_reg   <= 1'b0;
            valid_reg      <= '0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_vld_reg   <= proc_vld_next;
            valid_reg      <= valid_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
            rd_idx_reg     <= rd_idx_next;
        end
    end

    // Payload and index registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        item_reg     <= item_next;
        hit_reg      <= hit_next;
        free_idx_reg <= free_idx_next;
    end

endmodule

// File: rtl/core/iwt_checker.sv
// Port-level checker for the IRQ wait table and its bind.
module iwt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [7:0]  event_irq,
    input logic [31:0] event_stamp,
    input logic [31:0] event_data,
    input logic [31:0] event_context
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Requests accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    // A request occupies the table walk; no back-to-back acceptance
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("request accepted during a table walk");

    // No response without an outstanding request, and at most two in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid |-> pending_reg != 2'd0) and (pending_reg != 2'd3))
        else $error("response count does not match requests");

    // A stalled response holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                   && $stable(event_data))
        else $error("stalled response changed");

    // Only an ok status carries an event
    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != iwt_pkg::ST_OK |->
            event_irq == 8'd0 && event_stamp == 32'd0
            && event_data == 32'd0 && event_context == 32'd0)
        else $error("event fields set on a non-ok status");

    // Status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == iwt_pkg::ST_OK || status == iwt_pkg::ST_INVALID
            || status == iwt_pkg::ST_BUSY || status == iwt_pkg::ST_NOMEM
            || status == iwt_pkg::ST_WOULDBLOCK)
        else $error("undefined status code");

endmodule

bind irq_wait_table iwt_checker u_iwt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .event_irq     (rsp.event_irq),
    .event_stamp   (rsp.event_stamp),
    .event_data    (rsp.event_data),
    .event_context (rsp.event_context)
);
